/* hdl/assert_macros.svh */
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off while in reset.
`define C8IE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("c8ie check failed");

// Next-cycle implication, sampled on the rising clock, off while in reset.
`define C8IE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("c8ie check failed");

`endif

/* hdl/c8ie_pkg.sv */
// Types and constants shared by the CHIP-8 execute unit modules.
package c8ie_pkg;

    localparam int RF_DEPTH = 16;
    localparam logic [11:0] START_ADDR_RESET = 12'h200;

    // Instruction groups (top nibble)
    localparam logic [3:0] OP_SYS  = 4'h0;
    localparam logic [3:0] OP_JP   = 4'h1;
    localparam logic [3:0] OP_CALL = 4'h2;
    localparam logic [3:0] OP_SEI  = 4'h3;
    localparam logic [3:0] OP_SNEI = 4'h4;
    localparam logic [3:0] OP_SER  = 4'h5;
    localparam logic [3:0] OP_LDI  = 4'h6;
    localparam logic [3:0] OP_ADDI = 4'h7;
    localparam logic [3:0] OP_ALU  = 4'h8;
    localparam logic [3:0] OP_SNER = 4'h9;
    localparam logic [3:0] OP_LDIX = 4'hA;
    localparam logic [3:0] OP_JPV0 = 4'hB;
    localparam logic [3:0] OP_RND  = 4'hC;
    localparam logic [3:0] OP_DRW  = 4'hD;
    localparam logic [3:0] OP_KEY  = 4'hE;

    // ALU sub-codes (low nibble of 8XYn)
    localparam logic [3:0] ALU_MOV  = 4'h0;
    localparam logic [3:0] ALU_OR   = 4'h1;
    localparam logic [3:0] ALU_AND  = 4'h2;
    localparam logic [3:0] ALU_XOR  = 4'h3;
    localparam logic [3:0] ALU_ADD  = 4'h4;
    localparam logic [3:0] ALU_SUB  = 4'h5;
    localparam logic [3:0] ALU_SHR  = 4'h6;
    localparam logic [3:0] ALU_SUBN = 4'h7;
    localparam logic [3:0] ALU_SHL  = 4'hE;

    localparam logic [15:0] W_CLS = 16'h00E0;
    localparam logic [15:0] W_RET = 16'h00EE;
    localparam logic [7:0]  KEY_DOWN = 8'h9E;
    localparam logic [7:0]  KEY_UP   = 8'hA1;
    localparam logic [3:0]  REG_V0 = 4'h0;
    localparam logic [3:0]  REG_VF = 4'hF;

    typedef struct packed {
        logic [11:0] next_pc;
        logic        clear_request;
        logic        draw_request;
        logic [7:0]  draw_x_value;
        logic [7:0]  draw_y_value;
        logic [3:0]  draw_rows;
        logic [11:0] sprite_address;
        logic        unhandled;
        logic        stack_fault;
    } res_t;

    typedef struct packed {
        logic        x_we;
        logic [3:0]  x_addr;
        logic [7:0]  x_data;
        logic        f_we;
        logic        f_data;
        logic        index_we;
        logic [11:0] index_data;
    } wr_t;

    typedef struct packed {
        logic        push;
        logic        pop;
        logic [11:0] push_data;
    } stack_ctl_t;

    typedef struct packed {
        logic empty;
        logic full;
    } stack_stat_t;

endpackage

/* hdl/c8ie_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module c8ie_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/c8ie_stack.sv */
// Return stack: top two entries in registers, full contents in a RAM.
module c8ie_stack #(
    parameter int STACK_DEPTH = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  c8ie_pkg::stack_ctl_t ctl,
    output c8ie_pkg::stack_stat_t stat,
    output logic [11:0]          top
);

    localparam int LW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    logic [LW-1:0] level_reg;
    logic [LW-1:0] level_next;
    logic [LW-1:0] prefetch_idx;
    logic [11:0]   t0_reg;
    logic [11:0]   t1_reg;
    logic [11:0]   ram_rdata;

    always_comb
    begin
        level_next = level_reg;
        if (ctl.push)
        begin
            level_next = level_reg + LW'(1);
        end
        else if (ctl.pop)
        begin
            level_next = level_reg - LW'(1);
        end
    end

    // Keep the entry that a later pop will need as second-from-top in flight.
    assign prefetch_idx = level_next - LW'(3);

    c8ie_ram #(
        .WIDTH (12),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ctl.push),
        .waddr (level_reg[AW-1:0]),
        .wdata (ctl.push_data),
        .re    (1'b1),
        .raddr (prefetch_idx[AW-1:0]),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
        end
        else
        begin
            level_reg <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            t0_reg <= ctl.push_data;
            t1_reg <= t0_reg;
        end
        else if (ctl.pop)
        begin
            t0_reg <= t1_reg;
            t1_reg <= ram_rdata;
        end
    end

    assign stat.empty = (level_reg == '0);
    assign stat.full  = (level_reg == LW'(STACK_DEPTH));
    assign top        = t0_reg;

endmodule

/* hdl/c8ie_exec.sv */
// Instruction decode and execute logic for one instruction word.
module c8ie_exec (
    input  logic [15:0]           instr,
    input  logic [15:0]           keys,
    input  logic [7:0]            rnd,
    input  logic [7:0]            vx,
    input  logic [7:0]            vy,
    input  logic [7:0]            v0,
    input  logic [11:0]           pc,
    input  logic [11:0]           index,
    input  c8ie_pkg::stack_stat_t stk_stat,
    input  logic [11:0]           stk_top,
    output c8ie_pkg::res_t        res,
    output c8ie_pkg::wr_t         wr,
    output c8ie_pkg::stack_ctl_t  stk_ctl
);

    logic [3:0]  op;
    logic [3:0]  n;
    logic [7:0]  nn;
    logic [11:0] nnn;
    logic [11:0] pc_inc;
    logic [11:0] pc_skip;
    logic [11:0] next;
    logic [8:0]  sum;
    logic        key_hit;
    logic        unh;
    logic        sf;

    assign op      = instr[15:12];
    assign n       = instr[3:0];
    assign nn      = instr[7:0];
    assign nnn     = instr[11:0];
    assign pc_inc  = pc + 12'd2;
    assign pc_skip = pc + 12'd4;
    assign sum     = {1'b0, vx} + {1'b0, vy};
    assign key_hit = keys[vx[3:0]];

    always_comb
    begin
        next    = pc_inc;
        unh     = 1'b0;
        sf      = 1'b0;
        res     = '0;
        wr      = '0;
        stk_ctl = '0;
        wr.x_addr = instr[11:8];
        stk_ctl.push_data = pc_inc;

        unique case (op)
            c8ie_pkg::OP_SYS:
            begin
                if (instr == c8ie_pkg::W_CLS)
                begin
                    res.clear_request = 1'b1;
                end
                else if (instr == c8ie_pkg::W_RET)
                begin
                    if (stk_stat.empty)
                    begin
                        sf = 1'b1;
                    end
                    else
                    begin
                        stk_ctl.pop = 1'b1;
                        next = stk_top;
                    end
                end
                else
                begin
                    unh = 1'b1;
                end
            end
            c8ie_pkg::OP_JP:
            begin
                next = nnn;
            end
            c8ie_pkg::OP_CALL:
            begin
                if (stk_stat.full)
                begin
                    sf = 1'b1;
                end
                else
                begin
                    stk_ctl.push = 1'b1;
                    next = nnn;
                end
            end
            c8ie_pkg::OP_SEI:
            begin
                if (vx == nn)
                begin
                    next = pc_skip;
                end
            end
            c8ie_pkg::OP_SNEI:
            begin
                if (vx != nn)
                begin
                    next = pc_skip;
                end
            end
            c8ie_pkg::OP_SER:
            begin
                if (n != 4'h0)
                begin
                    unh = 1'b1;
                end
                else if (vx == vy)
                begin
                    next = pc_skip;
                end
            end
            c8ie_pkg::OP_LDI:
            begin
                wr.x_we   = 1'b1;
                wr.x_data = nn;
            end
            c8ie_pkg::OP_ADDI:
            begin
                wr.x_we   = 1'b1;
                wr.x_data = vx + nn;
            end
            c8ie_pkg::OP_ALU:
            begin
                unique case (n)
                    c8ie_pkg::ALU_MOV:
                    begin
                        wr.x_we   = 1'b1;
                        wr.x_data = vy;
                    end
                    c8ie_pkg::ALU_OR:
                    begin
                        wr.x_we   = 1'b1;
                        wr.x_data = vx | vy;
                    end
                    c8ie_pkg::ALU_AND:
                    begin
                        wr.x_we   = 1'b1;
                        wr.x_data = vx & vy;
                    end
                    c8ie_pkg::ALU_XOR:
                    begin
                        wr.x_we   = 1'b1;
                        wr.x_data = vx ^ vy;
                    end
                    c8ie_pkg::ALU_ADD:
                    begin
                        wr.x_we   = 1'b1;
                        wr.x_data = sum[7:0];
                        wr.f_we   = 1'b1;
                        wr.f_data = sum[8];
                    end
                    c8ie_pkg::ALU_SUB:
                    begin
                        wr.x_we   = 1'b1;
                        wr.x_data = vx - vy;
                        wr.f_we   = 1'b1;
                        wr.f_data = (vx >= vy);
                    end
                    c8ie_pkg::ALU_SHR:
                    begin
                        wr.x_we   = 1'b1;
                        wr.x_data = {1'b0, vx[7:1]};
                        wr.f_we   = 1'b1;
                        wr.f_data = vx[0];
                    end
                    c8ie_pkg::ALU_SUBN:
                    begin
                        wr.x_we   = 1'b1;
                        wr.x_data = vy - vx;
                        wr.f_we   = 1'b1;
                        wr.f_data = (vy >= vx);
                    end
                    c8ie_pkg::ALU_SHL:
                    begin
                        wr.x_we   = 1'b1;
                        wr.x_data = {vx[6:0], 1'b0};
                        wr.f_we   = 1'b1;
                        wr.f_data = vx[7];
                    end
                    default:
                    begin
                        unh = 1'b1;
                    end
                endcase
            end
            c8ie_pkg::OP_SNER:
            begin
                if (n != 4'h0)
                begin
                    unh = 1'b1;
                end
                else if (vx != vy)
                begin
                    next = pc_skip;
                end
            end
            c8ie_pkg::OP_LDIX:
            begin
                wr.index_we   = 1'b1;
                wr.index_data = nnn;
            end
            c8ie_pkg::OP_JPV0:
            begin
                next = nnn + {4'h0, v0};
            end
            c8ie_pkg::OP_RND:
            begin
                wr.x_we   = 1'b1;
                wr.x_data = rnd & nn;
            end
            c8ie_pkg::OP_DRW:
            begin
                res.draw_request   = 1'b1;
                res.draw_x_value   = vx;
                res.draw_y_value   = vy;
                res.draw_rows      = n;
                res.sprite_address = index;
            end
            c8ie_pkg::OP_KEY:
            begin
                if (nn == c8ie_pkg::KEY_DOWN)
                begin
                    if (key_hit)
                    begin
                        next = pc_skip;
                    end
                end
                else if (nn == c8ie_pkg::KEY_UP)
                begin
                    if (!key_hit)
                    begin
                        next = pc_skip;
                    end
                end
                else
                begin
                    unh = 1'b1;
                end
            end
            default:
            begin
                unh = 1'b1;
            end
        endcase

        // Faulted or undefined words leave the program counter where it is.
        if (unh || sf)
        begin
            next = pc;
        end

        res.next_pc     = next;
        res.unhandled   = unh;
        res.stack_fault = sf;
    end

endmodule

/* hdl/chip8_instruction_execute_unit.sv */
// Top level of the CHIP-8 instruction execute unit.
//
//  Channel | Signals                                  | Direction | Handshake
//  --------+------------------------------------------+-----------+----------------
//  in      | instr_word, keys_down, random_byte       | input     | in_valid/in_ready
//  out     | next_pc, clear_request, draw_request,    | output    | out_valid/out_ready
//          | draw_x/y_value, draw_rows,               |           |
//          | sprite_address, unhandled, stack_fault   |           |
//  cfg     | start_address                            | input     | cfg_we, no wait
//
//  From input transfer to result, each instruction passes the input register
//  (register-file RAM read), then decode/execute into the result register.
//  One instruction transfers per cycle when out_ready holds high.
//  Reset clears V0..VF, the index, the stack level, and loads the program counter
//  with 512. A stalled result holds in the result register while one more
//  instruction waits in the input register; in_ready drops only when both are full.
module chip8_instruction_execute_unit #(
    parameter int STACK_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] instr_word,
    input  logic [15:0] keys_down,
    input  logic [7:0]  random_byte,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [11:0] next_pc,
    output logic        clear_request,
    output logic        draw_request,
    output logic [7:0]  draw_x_value,
    output logic [7:0]  draw_y_value,
    output logic [3:0]  draw_rows,
    output logic [11:0] sprite_address,
    output logic        unhandled,
    output logic        stack_fault,

    input  logic        cfg_we,
    input  logic [11:0] start_address
);

    // There is no start address register: cfg_we and start_address are not used,
    // and reset always loads the program counter with 512, so a written value
    // never reaches the program counter. The write port is accepted and
    // has no visible effect.

    // Pipeline control
    logic        s1_valid_reg;
    logic        out_valid_reg;
    logic        out_free;
    logic        s1_move;
    logic        in_fire;

    // Stage 1 payload
    logic [15:0] s1_instr_reg;
    logic [15:0] s1_keys_reg;
    logic [7:0]  s1_rnd_reg;

    // Architectural state outside the RAMs
    logic [11:0] pc_reg;
    logic [11:0] index_reg;
    logic [7:0]  v0_reg;
    logic [7:0]  vf_reg;

    // One bit per register-file entry: set once the entry has been written since
    // reset, so an entry never written reads as zero.
    logic [c8ie_pkg::RF_DEPTH-1:0] rf_written_reg;
    logic        x_written_reg;
    logic        y_written_reg;

    // Register-file bypass: a write that landed in the same edge as the RAM read
    logic        byp_x_reg;
    logic        byp_y_reg;
    logic [7:0]  byp_data_reg;

    logic [7:0]  ram_x_rdata;
    logic [7:0]  ram_y_rdata;
    logic        rf_ram_we;
    logic [3:0]  s1_x;
    logic [3:0]  s1_y;
    logic [7:0]  vx;
    logic [7:0]  vy;

    c8ie_pkg::res_t        res;
    c8ie_pkg::res_t        res_reg;
    c8ie_pkg::wr_t         wr;
    c8ie_pkg::stack_ctl_t  stk_ctl;
    c8ie_pkg::stack_ctl_t  stk_ctl_gated;
    c8ie_pkg::stack_stat_t stk_stat;
    logic [11:0]           stk_top;

    // Handshake: advance stage 1 into the result register when it is free.
    assign out_free = !out_valid_reg || out_ready;
    assign s1_move  = s1_valid_reg && out_free;
    assign in_ready = !s1_valid_reg || s1_move;
    assign in_fire  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_instr_reg  <= instr_word;
            s1_keys_reg   <= keys_down;
            s1_rnd_reg    <= random_byte;
            byp_x_reg     <= s1_move && rf_ram_we && (wr.x_addr == instr_word[11:8]);
            byp_y_reg     <= s1_move && rf_ram_we && (wr.x_addr == instr_word[7:4]);
            byp_data_reg  <= wr.x_data;
            x_written_reg <= rf_written_reg[instr_word[11:8]];
            y_written_reg <= rf_written_reg[instr_word[7:4]];
        end
        if (s1_move)
        begin
            res_reg <= res;
        end
    end

    // V1..VE live in the RAM pair (one per read port); V0 and VF stay in flops
    // since BNNN reads V0 and flag ops write VF alongside VX.
    assign rf_ram_we = wr.x_we && (wr.x_addr != c8ie_pkg::REG_V0)
                       && (wr.x_addr != c8ie_pkg::REG_VF);

    c8ie_ram #(
        .WIDTH (8),
        .DEPTH (c8ie_pkg::RF_DEPTH)
    ) u_rf_x (
        .clk   (clk),
        .we    (s1_move && rf_ram_we),
        .waddr (wr.x_addr),
        .wdata (wr.x_data),
        .re    (in_fire),
        .raddr (instr_word[11:8]),
        .rdata (ram_x_rdata)
    );

    c8ie_ram #(
        .WIDTH (8),
        .DEPTH (c8ie_pkg::RF_DEPTH)
    ) u_rf_y (
        .clk   (clk),
        .we    (s1_move && rf_ram_we),
        .waddr (wr.x_addr),
        .wdata (wr.x_data),
        .re    (in_fire),
        .raddr (instr_word[7:4]),
        .rdata (ram_y_rdata)
    );

    assign s1_x = s1_instr_reg[11:8];
    assign s1_y = s1_instr_reg[7:4];

    always_comb
    begin
        if (s1_x == c8ie_pkg::REG_V0)
        begin
            vx = v0_reg;
        end
        else if (s1_x == c8ie_pkg::REG_VF)
        begin
            vx = vf_reg;
        end
        else if (byp_x_reg)
        begin
            vx = byp_data_reg;
        end
        else if (x_written_reg)
        begin
            vx = ram_x_rdata;
        end
        else
        begin
            vx = 8'h00;
        end

        if (s1_y == c8ie_pkg::REG_V0)
        begin
            vy = v0_reg;
        end
        else if (s1_y == c8ie_pkg::REG_VF)
        begin
            vy = vf_reg;
        end
        else if (byp_y_reg)
        begin
            vy = byp_data_reg;
        end
        else if (y_written_reg)
        begin
            vy = ram_y_rdata;
        end
        else
        begin
            vy = 8'h00;
        end
    end

    c8ie_exec u_exec (
        .instr    (s1_instr_reg),
        .keys     (s1_keys_reg),
        .rnd      (s1_rnd_reg),
        .vx       (vx),
        .vy       (vy),
        .v0       (v0_reg),
        .pc       (pc_reg),
        .index    (index_reg),
        .stk_stat (stk_stat),
        .stk_top  (stk_top),
        .res      (res),
        .wr       (wr),
        .stk_ctl  (stk_ctl)
    );

    // Stack moves only on the edge that commits the instruction.
    always_comb
    begin
        stk_ctl_gated      = stk_ctl;
        stk_ctl_gated.push = stk_ctl.push && s1_move;
        stk_ctl_gated.pop  = stk_ctl.pop && s1_move;
    end

    c8ie_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (stk_ctl_gated),
        .stat  (stk_stat),
        .top   (stk_top)
    );

    // Commit architectural state; the flag write wins over VX when X is F.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg         <= c8ie_pkg::START_ADDR_RESET;
            index_reg      <= '0;
            v0_reg         <= '0;
            vf_reg         <= '0;
            rf_written_reg <= '0;
        end
        else if (s1_move)
        begin
            pc_reg <= res.next_pc;
            if (wr.index_we)
            begin
                index_reg <= wr.index_data;
            end
            if (rf_ram_we)
            begin
                rf_written_reg[wr.x_addr] <= 1'b1;
            end
            if (wr.x_we && (wr.x_addr == c8ie_pkg::REG_V0))
            begin
                v0_reg <= wr.x_data;
            end
            if (wr.f_we)
            begin
                vf_reg <= {7'b0, wr.f_data};
            end
            else if (wr.x_we && (wr.x_addr == c8ie_pkg::REG_VF))
            begin
                vf_reg <= wr.x_data;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign next_pc        = res_reg.next_pc;
    assign clear_request  = res_reg.clear_request;
    assign draw_request   = res_reg.draw_request;
    assign draw_x_value   = res_reg.draw_x_value;
    assign draw_y_value   = res_reg.draw_y_value;
    assign draw_rows      = res_reg.draw_rows;
    assign sprite_address = res_reg.sprite_address;
    assign unhandled      = res_reg.unhandled;
    assign stack_fault    = res_reg.stack_fault;

endmodule

/* hdl/c8ie_chk.sv */
// Port-level checker for the CHIP-8 execute unit, with its bind.
`include "assert_macros.svh"

module c8ie_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [11:0] next_pc,
    input logic        clear_request,
    input logic        draw_request,
    input logic [7:0]  draw_x_value,
    input logic [7:0]  draw_y_value,
    input logic [3:0]  draw_rows,
    input logic [11:0] sprite_address,
    input logic        unhandled,
    input logic        stack_fault
);

    // A stalled result stays valid and holds its next_pc.
    `C8IE_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(next_pc))

    // A faulted or undefined word raises no display request.
    `C8IE_ASSERT_IMP(a_fault_no_req, clk, rst_n, out_valid && (unhandled || stack_fault), !clear_request && !draw_request)

    // Draw fields are zero unless a draw is requested.
    `C8IE_ASSERT_IMP(a_draw_zero, clk, rst_n, out_valid && !draw_request, (draw_x_value == 8'h00) && (draw_y_value == 8'h00) && (draw_rows == 4'h0) && (sprite_address == 12'h000))

    // A word is never both undefined and a stack fault.
    `C8IE_ASSERT_IMP(a_fault_excl, clk, rst_n, out_valid, !(unhandled && stack_fault))

endmodule

bind chip8_instruction_execute_unit c8ie_chk u_c8ie_chk (.*);

/* tb/sv/chip8_instruction_execute_unit_tb.sv */
// Self-checking testbench for the CHIP-8 instruction execute unit.
`timescale 1ns / 100ps

module chip8_instruction_execute_unit_tb;

    localparam int STACK_DEPTH = 16;
    // Cycles without any transfer before the run is declared hung.
    localparam int STALL_LIMIT = 4000;
    // The F group has no package constant, since the unit treats it as unhandled.
    localparam logic [3:0] GRP_MISC = 4'hF;

    // Every input of the unit starts at a known value.
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [15:0] instr_word = 16'h0000;
    logic [15:0] keys_down = 16'h0000;
    logic [7:0]  random_byte = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [11:0] next_pc;
    logic        clear_request;
    logic        draw_request;
    logic [7:0]  draw_x_value;
    logic [7:0]  draw_y_value;
    logic [3:0]  draw_rows;
    logic [11:0] sprite_address;
    logic        unhandled;
    logic        stack_fault;
    logic        cfg_we = 1'b0;
    logic [11:0] start_address = 12'h000;

    // Idle rates in percent for the sender and the receiver.
    int unsigned send_idle_pct = 0;
    int unsigned ready_idle_pct = 0;

    int mismatches = 0;
    int stall_cycles = 0;

    // Predicted architectural state of the core.
    logic [7:0]  v_file [16];
    logic [11:0] i_reg;
    logic [11:0] pc_now;
    logic [11:0] ret_stack [STACK_DEPTH];
    int          ret_depth;
    // Shadow of start_address; the unit never loads it, and reset happens once.
    logic [11:0] start_cfg;

    // Results predicted for accepted instructions, oldest first.
    c8ie_pkg::res_t predicted_results [$];

    chip8_instruction_execute_unit #(
        .STACK_DEPTH(STACK_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .instr_word(instr_word),
        .keys_down(keys_down),
        .random_byte(random_byte),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .next_pc(next_pc),
        .clear_request(clear_request),
        .draw_request(draw_request),
        .draw_x_value(draw_x_value),
        .draw_y_value(draw_y_value),
        .draw_rows(draw_rows),
        .sprite_address(sprite_address),
        .unhandled(unhandled),
        .stack_fault(stack_fault),
        .cfg_we(cfg_we),
        .start_address(start_address)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Execute one instruction against the predicted state and return its result.
    // Faulting and unhandled instructions leave the state alone and hold the PC.
    function automatic c8ie_pkg::res_t execute_instr(input logic [15:0] w,
                                                     input logic [15:0] keys,
                                                     input logic [7:0] rnd);
        c8ie_pkg::res_t r;
        logic [3:0]  x;
        logic [3:0]  y;
        logic [3:0]  n;
        logic [7:0]  nn;
        logic [7:0]  vx;
        logic [7:0]  vy;
        logic [11:0] nnn;
        logic [11:0] nxt;
        logic [11:0] skp;
        logic [8:0]  wide;
        logic        flag;
        x = w[11:8];
        y = w[7:4];
        n = w[3:0];
        nn = w[7:0];
        nnn = w[11:0];
        vx = v_file[x];
        vy = v_file[y];
        nxt = pc_now + 12'd2;
        skp = pc_now + 12'd4;
        r = '0;
        case (w[15:12])
            c8ie_pkg::OP_SYS:
            begin
                if (w == c8ie_pkg::W_CLS)
                    r.clear_request = 1'b1;
                else if (w == c8ie_pkg::W_RET)
                begin
                    if (ret_depth == 0)
                        r.stack_fault = 1'b1;
                    else
                    begin
                        ret_depth--;
                        nxt = ret_stack[ret_depth];
                    end
                end
                else
                    r.unhandled = 1'b1;
            end
            c8ie_pkg::OP_JP: nxt = nnn;
            c8ie_pkg::OP_CALL:
            begin
                if (ret_depth >= STACK_DEPTH)
                    r.stack_fault = 1'b1;
                else
                begin
                    ret_stack[ret_depth] = nxt;
                    ret_depth++;
                    nxt = nnn;
                end
            end
            c8ie_pkg::OP_SEI: if (vx == nn) nxt = skp;
            c8ie_pkg::OP_SNEI: if (vx != nn) nxt = skp;
            c8ie_pkg::OP_SER:
            begin
                if (n != 4'h0)
                    r.unhandled = 1'b1;
                else if (vx == vy)
                    nxt = skp;
            end
            c8ie_pkg::OP_LDI: v_file[x] = nn;
            c8ie_pkg::OP_ADDI: v_file[x] = vx + nn;
            c8ie_pkg::OP_ALU:
            begin
                // VF is written after VX so the flag wins when X is VF.
                case (n)
                    c8ie_pkg::ALU_MOV: v_file[x] = vy;
                    c8ie_pkg::ALU_OR: v_file[x] = vx | vy;
                    c8ie_pkg::ALU_AND: v_file[x] = vx & vy;
                    c8ie_pkg::ALU_XOR: v_file[x] = vx ^ vy;
                    c8ie_pkg::ALU_ADD:
                    begin
                        wide = {1'b0, vx} + {1'b0, vy};
                        v_file[x] = wide[7:0];
                        v_file[c8ie_pkg::REG_VF] = {7'b0, wide[8]};
                    end
                    c8ie_pkg::ALU_SUB:
                    begin
                        flag = (vx >= vy);
                        v_file[x] = vx - vy;
                        v_file[c8ie_pkg::REG_VF] = {7'b0, flag};
                    end
                    c8ie_pkg::ALU_SHR:
                    begin
                        flag = vx[0];
                        v_file[x] = vx >> 1;
                        v_file[c8ie_pkg::REG_VF] = {7'b0, flag};
                    end
                    c8ie_pkg::ALU_SUBN:
                    begin
                        flag = (vy >= vx);
                        v_file[x] = vy - vx;
                        v_file[c8ie_pkg::REG_VF] = {7'b0, flag};
                    end
                    c8ie_pkg::ALU_SHL:
                    begin
                        flag = vx[7];
                        v_file[x] = vx << 1;
                        v_file[c8ie_pkg::REG_VF] = {7'b0, flag};
                    end
                    default: r.unhandled = 1'b1;
                endcase
            end
            c8ie_pkg::OP_SNER:
            begin
                if (n != 4'h0)
                    r.unhandled = 1'b1;
                else if (vx != vy)
                    nxt = skp;
            end
            c8ie_pkg::OP_LDIX: i_reg = nnn;
            c8ie_pkg::OP_JPV0: nxt = nnn + {4'h0, v_file[c8ie_pkg::REG_V0]};
            c8ie_pkg::OP_RND: v_file[x] = rnd & nn;
            c8ie_pkg::OP_DRW:
            begin
                r.draw_request = 1'b1;
                r.draw_x_value = vx;
                r.draw_y_value = vy;
                r.draw_rows = n;
                r.sprite_address = i_reg;
            end
            c8ie_pkg::OP_KEY:
            begin
                // Only the low nibble of VX names the key.
                flag = keys[vx[3:0]];
                if (nn == c8ie_pkg::KEY_DOWN)
                begin
                    if (flag)
                        nxt = skp;
                end
                else if (nn == c8ie_pkg::KEY_UP)
                begin
                    if (!flag)
                        nxt = skp;
                end
                else
                    r.unhandled = 1'b1;
            end
            default: r.unhandled = 1'b1;
        endcase
        if (r.unhandled || r.stack_fault)
            nxt = pc_now;
        pc_now = nxt;
        r.next_pc = nxt;
        return r;
    endfunction

    // Build a mostly well-formed instruction; sub-codes are biased toward the
    // defined ones so the ALU, skips and key tests get exercised.
    function automatic logic [15:0] random_instr();
        logic [3:0]  grp;
        logic [11:0] arg;
        int unsigned pick;
        grp = 4'($urandom);
        arg = 12'($urandom);
        case (grp)
            c8ie_pkg::OP_SYS:
            begin
                pick = $urandom_range(3);
                if (pick == 0)
                    arg = c8ie_pkg::W_CLS[11:0];
                else if (pick != 3)
                    arg = c8ie_pkg::W_RET[11:0];
            end
            c8ie_pkg::OP_SEI, c8ie_pkg::OP_SNEI:
            begin
                // Half the time compare against the current register value.
                if ($urandom_range(1) != 0)
                    arg[7:0] = v_file[arg[11:8]];
            end
            c8ie_pkg::OP_SER, c8ie_pkg::OP_SNER:
            begin
                if ($urandom_range(3) != 0)
                    arg[3:0] = 4'h0;
            end
            c8ie_pkg::OP_LDI, c8ie_pkg::OP_ADDI:
            begin
                if ($urandom_range(3) == 0)
                    arg[7:0] = ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
            end
            c8ie_pkg::OP_ALU:
            begin
                if ($urandom_range(5) != 0)
                begin
                    case ($urandom_range(8))
                        0: arg[3:0] = c8ie_pkg::ALU_MOV;
                        1: arg[3:0] = c8ie_pkg::ALU_OR;
                        2: arg[3:0] = c8ie_pkg::ALU_AND;
                        3: arg[3:0] = c8ie_pkg::ALU_XOR;
                        4: arg[3:0] = c8ie_pkg::ALU_ADD;
                        5: arg[3:0] = c8ie_pkg::ALU_SUB;
                        6: arg[3:0] = c8ie_pkg::ALU_SHR;
                        7: arg[3:0] = c8ie_pkg::ALU_SUBN;
                        default: arg[3:0] = c8ie_pkg::ALU_SHL;
                    endcase
                end
            end
            c8ie_pkg::OP_KEY:
            begin
                if ($urandom_range(3) != 0)
                    arg[7:0] = ($urandom_range(1) != 0) ? c8ie_pkg::KEY_DOWN
                                                         : c8ie_pkg::KEY_UP;
            end
            default: ;
        endcase
        return {grp, arg};
    endfunction

    // Print one mismatch line and count it.
    task automatic report_mismatch(input string what, input logic [11:0] want,
                                   input logic [11:0] got);
        $display("%0t mismatch on %s: expected 0x%0h, got 0x%0h", $realtime, what,
                 want, got);
        mismatches++;
    endtask

    task automatic check_field(input string what, input logic [11:0] want,
                               input logic [11:0] got);
        if (got !== want)
            report_mismatch(what, want, got);
    endtask

    // Present one instruction and hold it until the unit takes it. Entered and
    // left at a falling edge; valid is left high so back-to-back transfers need
    // no second assignment in the same step.
    task automatic issue_instr(input logic [15:0] w, input logic [15:0] keys,
                               input logic [7:0] rnd);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        instr_word <= w;
        keys_down <= keys;
        random_byte <= rnd;
        do
            @(posedge clk);
        while (!in_ready);
        // Predict at the transfer edge; the result cannot show up before it.
        predicted_results.push_back(execute_instr(w, keys, rnd));
        @(negedge clk);
    endtask

    task automatic run_op(input logic [15:0] w);
        issue_instr(w, 16'($urandom), 8'($urandom));
    endtask

    // Drop valid, drain every pending result, then let the pipeline go quiet.
    task automatic settle_idle();
        in_valid <= 1'b0;
        while (predicted_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // The unit never loads the PC from it, so the prediction keeps running
    // from the current PC; write only with the unit idle.
    task automatic write_start_address(input logic [11:0] value);
        settle_idle();
        cfg_we <= 1'b1;
        start_address <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        start_cfg = value;
        @(negedge clk);
    endtask

    // Field extremes, the ADD, SUB, SUBN, SHR, SHL and XOR ALU ops, flag-register
    // priority, wrapping jumps, key numbers taken from the low nibble and the undefined encodings.
    task automatic test_directed_ops();
        run_op(c8ie_pkg::W_CLS);
        run_op({c8ie_pkg::OP_LDI, c8ie_pkg::REG_V0, 8'hFF});
        run_op({c8ie_pkg::OP_LDI, 4'h1, 8'h01});
        // Carry out, V0 wraps to zero.
        run_op({c8ie_pkg::OP_ALU, c8ie_pkg::REG_V0, 4'h1, c8ie_pkg::ALU_ADD});
        run_op({c8ie_pkg::OP_ADDI, c8ie_pkg::REG_V0, 8'hFF});
        // X is VF: the flag must win.
        run_op({c8ie_pkg::OP_ALU, c8ie_pkg::REG_VF, c8ie_pkg::REG_V0, c8ie_pkg::ALU_ADD});
        // Borrow.
        run_op({c8ie_pkg::OP_ALU, 4'h1, c8ie_pkg::REG_V0, c8ie_pkg::ALU_SUB});
        run_op({c8ie_pkg::OP_ALU, c8ie_pkg::REG_V0, 4'h1, c8ie_pkg::ALU_SUBN});
        run_op({c8ie_pkg::OP_ALU, c8ie_pkg::REG_V0, c8ie_pkg::REG_V0, c8ie_pkg::ALU_SHR});
        run_op({c8ie_pkg::OP_LDI, 4'h2, 8'h80});
        // Top bit shifted out into VF.
        run_op({c8ie_pkg::OP_ALU, 4'h2, c8ie_pkg::REG_V0, c8ie_pkg::ALU_SHL});
        run_op({c8ie_pkg::OP_ALU, 4'h1, 4'h2, c8ie_pkg::ALU_XOR});
        run_op({c8ie_pkg::OP_SEI, c8ie_pkg::REG_V0, 8'h01});
        run_op({c8ie_pkg::OP_SNEI, c8ie_pkg::REG_V0, 8'h01});
        run_op({c8ie_pkg::OP_SER, c8ie_pkg::REG_V0, 4'h1, 4'h0});
        run_op({c8ie_pkg::OP_SNER, c8ie_pkg::REG_V0, 4'h1, 4'h0});
        run_op({c8ie_pkg::OP_LDIX, 12'hFFF});
        run_op({c8ie_pkg::OP_DRW, c8ie_pkg::REG_V0, 4'h1, 4'hF});
        // NNN + V0 wraps past 4095.
        run_op({c8ie_pkg::OP_JPV0, 12'hFFF});
        issue_instr({c8ie_pkg::OP_RND, 4'h3, 8'hFF}, 16'($urandom), 8'hA5);
        // Key number is 3, not 0xF3.
        run_op({c8ie_pkg::OP_LDI, 4'h4, 8'hF3});
        issue_instr({c8ie_pkg::OP_KEY, 4'h4, c8ie_pkg::KEY_DOWN}, 16'h0008, 8'($urandom));
        issue_instr({c8ie_pkg::OP_KEY, 4'h4, c8ie_pkg::KEY_UP}, 16'hFFF7, 8'($urandom));
        run_op({c8ie_pkg::OP_SYS, 12'h123});
        run_op({c8ie_pkg::OP_ALU, c8ie_pkg::REG_V0, 4'h1, 4'h8});
        run_op({c8ie_pkg::OP_KEY, 4'h4, 8'hFF});
        run_op({GRP_MISC, 12'h000});
    endtask

    // Return with nothing on the stack, calls that wrap the return address,
    // then unwind back to a fault.
    task automatic test_call_return();
        run_op(c8ie_pkg::W_RET);
        run_op({c8ie_pkg::OP_JP, 12'hFFE});
        run_op({c8ie_pkg::OP_CALL, 12'h000});
        run_op({c8ie_pkg::OP_CALL, 12'hFFF});
        run_op(c8ie_pkg::W_RET);
        run_op(c8ie_pkg::W_RET);
        run_op(c8ie_pkg::W_RET);
    endtask

    // Random program: mostly shaped instructions, some call/return runs deep
    // enough to hit both stack limits, and a share of raw noise words.
    task automatic test_random_program(input int unsigned count);
        int unsigned issued;
        int unsigned burst;
        issued = 0;
        while (issued < count)
        begin
            if ($urandom_range(39) == 0)
            begin
                burst = $urandom_range(4, 18);
                repeat (burst) run_op({c8ie_pkg::OP_CALL, 12'($urandom)});
                issued += burst;
                burst = $urandom_range(4, 18);
                repeat (burst) run_op(c8ie_pkg::W_RET);
                issued += burst;
            end
            else if ($urandom_range(9) == 0)
            begin
                run_op(16'($urandom));
                issued++;
            end
            else
            begin
                run_op(random_instr());
                issued++;
            end
        end
    endtask

    // Receiver: decide ready at each falling edge.
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= ready_idle_pct);

    // Check every result transfer against the oldest prediction.
    always @(posedge clk)
    begin : result_check
        c8ie_pkg::res_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (predicted_results.size() == 0)
                report_mismatch("unexpected result, next_pc", 12'h000, next_pc);
            else
            begin
                want = predicted_results.pop_front();
                check_field("next_pc", want.next_pc, next_pc);
                check_field("clear_request", 12'(want.clear_request), 12'(clear_request));
                check_field("draw_request", 12'(want.draw_request), 12'(draw_request));
                check_field("draw_x_value", 12'(want.draw_x_value), 12'(draw_x_value));
                check_field("draw_y_value", 12'(want.draw_y_value), 12'(draw_y_value));
                check_field("draw_rows", 12'(want.draw_rows), 12'(draw_rows));
                check_field("sprite_address", want.sprite_address, sprite_address);
                check_field("unhandled", 12'(want.unhandled), 12'(unhandled));
                check_field("stack_fault", 12'(want.stack_fault), 12'(stack_fault));
            end
        end
    end

    // Watchdog: any transfer on either channel restarts the count.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        for (int i = 0; i < 16; i++)
            v_file[i] = 8'h00;
        for (int i = 0; i < STACK_DEPTH; i++)
            ret_stack[i] = 12'h000;
        i_reg = 12'h000;
        pc_now = c8ie_pkg::START_ADDR_RESET;
        ret_depth = 0;
        start_cfg = c8ie_pkg::START_ADDR_RESET;

        // Hold reset, then release it at a falling edge.
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        write_start_address(12'hFFF);
        test_directed_ops();
        test_call_return();

        // Sender mostly busy, receiver mostly stalled: results back up.
        send_idle_pct = 38;
        ready_idle_pct = 83;
        test_random_program(215);

        write_start_address(12'h000);
        // Sender starved, receiver mostly ready.
        send_idle_pct = 83;
        ready_idle_pct = 38;
        test_random_program(215);

        write_start_address(12'($urandom));
        // Full rate in both directions.
        send_idle_pct = 0;
        ready_idle_pct = 0;
        test_random_program(220);

        settle_idle();
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
